FILE: sv/operator_token_lexer_assert.svh
// Assertion macros for the operator token lexer.
// Used by files that carry concurrent checks; expects clock and reset in scope.
`ifndef OPERATOR_TOKEN_LEXER_ASSERT_SVH
`define OPERATOR_TOKEN_LEXER_ASSERT_SVH

// same-cycle implication
`define OTL_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("operator_token_lexer: same-cycle check failed");

// next-cycle implication
`define OTL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("operator_token_lexer: next-cycle check failed");

`endif

FILE: sv/olex_pkg.sv
// Shared types, token codes and classification functions for the operator lexer.
// No dependencies.
`default_nettype none

package olex_pkg;

   localparam int QueueDepthDefault = 4;

   localparam logic [3:0] PfxNone   = 4'd0;
   localparam logic [3:0] PfxSlash  = 4'd1;
   localparam logic [3:0] PfxTilde  = 4'd2;
   localparam logic [3:0] PfxLt     = 4'd3;
   localparam logic [3:0] PfxGt     = 4'd4;
   localparam logic [3:0] PfxAssign = 4'd5;
   localparam logic [3:0] PfxColon  = 4'd6;
   localparam logic [3:0] PfxDot    = 4'd7;
   localparam logic [3:0] PfxDotDot = 4'd8;

   localparam logic [5:0] TokPlus     = 6'd0;
   localparam logic [5:0] TokMinus    = 6'd1;
   localparam logic [5:0] TokStar     = 6'd2;
   localparam logic [5:0] TokPercent  = 6'd3;
   localparam logic [5:0] TokCaret    = 6'd4;
   localparam logic [5:0] TokHash     = 6'd5;
   localparam logic [5:0] TokAmp      = 6'd6;
   localparam logic [5:0] TokPipe     = 6'd7;
   localparam logic [5:0] TokLParen   = 6'd8;
   localparam logic [5:0] TokRParen   = 6'd9;
   localparam logic [5:0] TokLBrace   = 6'd10;
   localparam logic [5:0] TokRBrace   = 6'd11;
   localparam logic [5:0] TokLBracket = 6'd12;
   localparam logic [5:0] TokRBracket = 6'd13;
   localparam logic [5:0] TokSemi     = 6'd14;
   localparam logic [5:0] TokComma    = 6'd15;
   localparam logic [5:0] TokSlash    = 6'd16;
   localparam logic [5:0] TokDSlash   = 6'd17;
   localparam logic [5:0] TokTilde    = 6'd18;
   localparam logic [5:0] TokNe       = 6'd19;
   localparam logic [5:0] TokLt       = 6'd20;
   localparam logic [5:0] TokShl      = 6'd21;
   localparam logic [5:0] TokLe       = 6'd22;
   localparam logic [5:0] TokGt       = 6'd23;
   localparam logic [5:0] TokShr      = 6'd24;
   localparam logic [5:0] TokGe       = 6'd25;
   localparam logic [5:0] TokAssign   = 6'd26;
   localparam logic [5:0] TokEq       = 6'd27;
   localparam logic [5:0] TokColon    = 6'd28;
   localparam logic [5:0] TokDColon   = 6'd29;
   localparam logic [5:0] TokDot      = 6'd30;
   localparam logic [5:0] TokConcat   = 6'd31;
   localparam logic [5:0] TokDots     = 6'd32;
   localparam logic [5:0] TokNoMatch  = 6'd33;

   // extension results that are not tokens
   localparam logic [5:0] ExtNone   = 6'd0;
   localparam logic [5:0] ExtDotDot = 6'd63;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_marker;
   } req_payload_type;

   typedef struct packed {
      logic [5:0] token_code;
      logic [7:0] unmatched_byte;
      logic       last;
   } rsp_payload_type;

   typedef struct packed {
      logic            two;
      rsp_payload_type first;
      rsp_payload_type second;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } push_type;

   typedef struct packed {
      logic pop;
      logic sel;
   } back_status_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] code;
   } tok_hit_type;

   function automatic tok_hit_type single_code(input logic [7:0] b);
      tok_hit_type r;
      r.hit = 1'b1;
      unique case (b)
         "+":     r.code = TokPlus;
         "-":     r.code = TokMinus;
         "*":     r.code = TokStar;
         "%":     r.code = TokPercent;
         "^":     r.code = TokCaret;
         "#":     r.code = TokHash;
         "&":     r.code = TokAmp;
         "|":     r.code = TokPipe;
         "(":     r.code = TokLParen;
         ")":     r.code = TokRParen;
         "{":     r.code = TokLBrace;
         "}":     r.code = TokRBrace;
         "[":     r.code = TokLBracket;
         "]":     r.code = TokRBracket;
         ";":     r.code = TokSemi;
         ",":     r.code = TokComma;
         default: begin
            r.hit  = 1'b0;
            r.code = TokNoMatch;
         end
      endcase
      return r;
   endfunction

   function automatic logic [3:0] starter_code(input logic [7:0] b);
      logic [3:0] r;
      unique case (b)
         "/":     r = PfxSlash;
         "~":     r = PfxTilde;
         "<":     r = PfxLt;
         ">":     r = PfxGt;
         "=":     r = PfxAssign;
         ":":     r = PfxColon;
         ".":     r = PfxDot;
         default: r = PfxNone;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] pfx_token(input logic [3:0] p);
      logic [5:0] r;
      unique case (p)
         PfxSlash:  r = TokSlash;
         PfxTilde:  r = TokTilde;
         PfxLt:     r = TokLt;
         PfxGt:     r = TokGt;
         PfxAssign: r = TokAssign;
         PfxColon:  r = TokColon;
         PfxDot:    r = TokDot;
         PfxDotDot: r = TokConcat;
         default:   r = TokPlus;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] extend_tok(input logic [3:0] p, input logic [7:0] b);
      logic [5:0] r;
      r = ExtNone;
      unique case (p)
         PfxSlash:  if (b == "/") r = TokDSlash;
         PfxTilde:  if (b == "=") r = TokNe;
         PfxLt:     r = (b == "<") ? TokShl : (b == "=") ? TokLe : ExtNone;
         PfxGt:     r = (b == ">") ? TokShr : (b == "=") ? TokGe : ExtNone;
         PfxAssign: if (b == "=") r = TokEq;
         PfxColon:  if (b == ":") r = TokDColon;
         PfxDot:    if (b == ".") r = ExtDotDot;
         PfxDotDot: if (b == ".") r = TokDots;
         default:   r = ExtNone;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: sv/operator_token_lexer.sv
// Operator token lexer, top level: front end, entry queue and back end.
// Depends on olex_pkg, olex_front, olex_queue, olex_back and the assert macros.
//
// Usage:
//   req channel: one byte per transaction (char_byte), or end_marker set to
//   flush a pending prefix. Accepted when req_valid and req_ready are high.
//   rsp channel: token_code, unmatched_byte and last; last marks the final
//   result of an input transaction. A byte may yield zero, one or two results.
// Path: an accepted byte enters the queue at the accepting edge, then moves
//   from the queue head into the rsp output register.
// Throughput: one input per cycle while the queue is not full; one result per
//   cycle from the rsp register while rsp_ready is high; a two-result byte
//   holds its entry. The QueueDepth-entry queue absorbs that and output stalls.
// Stalls: while rsp_ready is low the output register holds; the front keeps
//   accepting until the queue fills, then req_ready drops.
// Reset: synchronous, active high; clears the pending prefix, empties the
//   queue and drops rsp_valid.
`default_nettype none

module operator_token_lexer
   import olex_pkg::*;
#(
   parameter int QueueDepth = QueueDepthDefault
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload
);

   localparam int CntW = $clog2(QueueDepth+1);

   push_type        push;
   logic            q_full;
   logic            q_valid;
   queue_entry_type q_head;
   logic [CntW-1:0] q_count;
   back_status_type back_status;

   olex_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_full      (q_full),
      .push        (push)
   );

   olex_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (back_status.pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head       (q_head),
      .count      (q_count)
   );

   olex_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_valid),
      .head        (q_head),
      .status      (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

`include "operator_token_lexer_assert.svh"

   `OTL_ASSERT_IMP(a_count_bound, 1'b1, q_count <= CntW'(QueueDepth))
   `OTL_ASSERT_IMP(a_pop_nonempty, back_status.pop, q_valid)
   `OTL_ASSERT_IMP(a_sel_two, back_status.sel, q_valid && q_head.two)
   `OTL_ASSERT_NEXT(a_second_last, back_status.sel && rsp_valid && rsp_ready, rsp_payload.last)

endmodule

`default_nettype wire

FILE: sv/olex_front.sv
// Front end: accepts transactions, tracks the pending operator prefix and
// classifies each byte into zero, one or two results. Depends on olex_pkg.
`default_nettype none

module olex_front
   import olex_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   input  wire logic            q_full,
   output push_type             push
);

   logic [3:0]      prefix_ff, prefix_in;
   logic [3:0]      p_eff;
   logic [5:0]      ext;
   tok_hit_type     sc;
   logic [3:0]      st;
   logic            accept;
   logic            have_flush, have_byte, have_any;
   rsp_payload_type flush_r, byte_r;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      p_eff      = (prefix_ff > PfxDotDot) ? PfxNone : prefix_ff;
      ext        = extend_tok(p_eff, req_payload.char_byte);
      sc         = single_code(req_payload.char_byte);
      st         = starter_code(req_payload.char_byte);
      flush_r    = '{token_code: pfx_token(p_eff), unmatched_byte: 8'd0, last: 1'b0};
      byte_r     = '{token_code: sc.code, unmatched_byte: 8'd0, last: 1'b1};
      have_flush = 1'b0;
      have_byte  = 1'b0;
      prefix_in  = PfxNone;
      if (req_payload.end_marker) begin
         have_flush = (p_eff != PfxNone);
      end else if (p_eff != PfxNone && ext == ExtDotDot) begin
         prefix_in = PfxDotDot;
      end else if (p_eff != PfxNone && ext != ExtNone) begin
         have_flush         = 1'b1;
         flush_r.token_code = ext;
      end else begin
         have_flush = (p_eff != PfxNone);
         if (sc.hit) begin
            have_byte = 1'b1;
         end else if (st != PfxNone) begin
            prefix_in = st;
         end else begin
            have_byte             = 1'b1;
            byte_r.token_code     = TokNoMatch;
            byte_r.unmatched_byte = req_payload.char_byte;
         end
      end
      have_any = have_flush || have_byte;

      push.valid        = accept && have_any;
      push.entry.two    = have_flush && have_byte;
      push.entry.second = byte_r;
      if (have_flush) begin
         push.entry.first      = flush_r;
         push.entry.first.last = !have_byte;
      end else begin
         push.entry.first = byte_r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= PfxNone;
      end else if (accept) begin
         prefix_ff <= prefix_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/olex_queue.sv
// Short FIFO of classified entries between the front and back ends.
// Depends on olex_pkg.
`default_nettype none

module olex_queue
   import olex_pkg::*;
#(
   parameter int Depth = QueueDepthDefault
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire push_type  push,
   input  wire logic      pop,
   output logic           full,
   output logic           head_valid,
   output queue_entry_type head,
   output logic [$clog2(Depth+1)-1:0] count
);

   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth+1);

   queue_entry_type store_ff [Depth];
   logic [AddrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AddrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head       = store_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AddrW'(Depth-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AddrW'(Depth-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/olex_back.sv
// Back end: drains queue entries into the registered result channel,
// one result per cycle while rsp_ready is high. Depends on olex_pkg.
`default_nettype none

module olex_back
   import olex_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            head_valid,
   input  wire queue_entry_type head,
   output back_status_type     status,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output rsp_payload_type     rsp_payload
);

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic            sel_ff, sel_in;
   logic            load;

   assign load        = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      sel_in         = sel_ff;
      status.pop     = 1'b0;
      status.sel     = sel_ff;
      if (load) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            rsp_payload_in = sel_ff ? head.second : head.first;
            status.pop     = !head.two || sel_ff;
            sel_in         = head.two && !sel_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
      end
   end

endmodule

`default_nettype wire
